>>> rtl/asg_pkg.sv
// Shared constants for the audio silence gate: register indexes, reset values, default sizes.
package asg_pkg;

   localparam int WINDOW_LEN_DEF = 64;

   localparam int SAMPLE_W  = 16;
   localparam int THRESH_W  = 15;
   localparam int HOLD_W    = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int RSP_DAT_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD      = 8'd1;

   localparam logic [THRESH_W-1:0] THRESHOLD_RST = 15'd4915;
   localparam logic [HOLD_W-1:0]   HOLD_RST      = 16'd8;

endpackage

>>> rtl/audio_silence_gate_with_hold.sv
// Silence gate with hold: window store, running sum, window scan and decision sequencer.
//
//   channel  dir  handshake               word
//   req      in   req_tvalid/req_tready   sample
//   rsp      out  rsp_tvalid/rsp_tready   ready_res, silent, window_mean, window_range
//   csr      in   csr_valid/csr_ready     csr_index, csr_data
//
// A word is accepted only in idle, and the next one only after its result is loaded: an update
// step, the window walked through the single read port of the window store, one entry a
// cycle, then one step each to finish the last compare, decide and load the output register.
// The mean comes from a constant reciprocal multiply. Start-up words go from the update
// straight to the output register and give an all-zero result.
// Reset is synchronous and clears all control state; the window store is not cleared,
// a fill count stands in for its zero reset. A stalled result holds in the output register
// while the next word is accepted; the sequencer waits only if that register is still full.
module audio_silence_gate_with_hold #(
   parameter int WINDOW_LEN = asg_pkg::WINDOW_LEN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [asg_pkg::SAMPLE_W-1:0]   req_tdata,   // [15:0] sample
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [asg_pkg::RSP_DAT_W-1:0]  rsp_tdata,   // [0] ready_res, [1] silent,
                                                       // [17:2] window_mean,
                                                       // [33:18] window_range, [39:34] zero
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [asg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [asg_pkg::CSR_DAT_W-1:0]  csr_data
);

   localparam int LOG_N = $clog2(WINDOW_LEN);
   localparam int AW    = LOG_N;
   localparam int SUM_W = 16 + LOG_N;
   localparam int SC_W  = $clog2(WINDOW_LEN + 2);
   localparam int PRD_W = 15 + LOG_N;
   localparam int REC_K = SUM_W + LOG_N;
   localparam int MUL_W = 2 * SUM_W + 1;

   localparam logic [AW-1:0]    LAST_ADDR = AW'(WINDOW_LEN - 1);
   localparam logic [SC_W-1:0]  FILL_N    = SC_W'(WINDOW_LEN);
   localparam logic [SUM_W-1:0] DIV_OFS   = SUM_W'(WINDOW_LEN * 32768);
   localparam logic [SUM_W:0]   REC_M     = (SUM_W + 1)'(((64'd1 << REC_K)
                                            + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
   localparam logic [PRD_W-1:0] PRD_N     = PRD_W'(WINDOW_LEN);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_UPD   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic signed [15:0] mem [WINDOW_LEN];
   logic signed [15:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               mem_we;

   logic [2:0]                   state_ff, state_in;
   logic signed [15:0]           sample_ff, sample_in;
   logic [AW-1:0]                wp_ff, wp_in;
   logic [AW-1:0]                scan_ff, scan_in;
   logic [SC_W-1:0]              startup_ff, startup_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [15:0]           mx_ff, mx_in, mn_ff, mn_in;
   logic                         cmp_vld_ff, cmp_vld_in;
   logic [asg_pkg::HOLD_W-1:0]   hold_ff, hold_in;
   logic                         silent_ff, silent_in;
   logic                         res_ready_ff, res_ready_in;
   logic                         res_silent_ff, res_silent_in;
   logic [15:0]                  range_ff, range_in;
   logic [15:0]                  quo_ff, quo_in;
   logic [asg_pkg::THRESH_W-1:0] threshold_ff;
   logic [asg_pkg::HOLD_W-1:0]   hold_count_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [asg_pkg::RSP_DAT_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [15:0]      old_val;
   logic [16:0]             diff;
   logic [PRD_W-1:0]        thr_prod;
   logic                    cand;
   logic [SUM_W-1:0]        div_u;
   logic [MUL_W-1:0]        div_p;
   logic                    rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign rd_addr  = (state_ff == S_SCAN) ? scan_ff : wp_ff;
   assign mem_we   = (state_ff == S_UPD);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign old_val  = (startup_ff < FILL_N) ? 16'sd0 : rd_data_ff;
   assign diff     = {mx_ff[15], mx_ff} - {mn_ff[15], mn_ff};
   assign thr_prod = PRD_W'(threshold_ff) * PRD_N;
   assign cand     = (sum_ff < $signed({1'b0, thr_prod})) && (diff[15:0] < {1'b0, threshold_ff});
   assign div_u    = sum_ff + DIV_OFS;
   assign div_p    = MUL_W'(div_u) * MUL_W'(REC_M);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= sample_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      wp_in         = wp_ff;
      scan_in       = scan_ff;
      startup_in    = startup_ff;
      sum_in        = sum_ff;
      mx_in         = mx_ff;
      mn_in         = mn_ff;
      cmp_vld_in    = 1'b0;
      hold_in       = hold_ff;
      silent_in     = silent_ff;
      res_ready_in  = res_ready_ff;
      res_silent_in = res_silent_ff;
      range_in      = range_ff;
      quo_in        = quo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      if (cmp_vld_ff) begin
         if (rd_data_ff > mx_ff) mx_in = rd_data_ff;
         if (rd_data_ff < mn_ff) mn_in = rd_data_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sample_in = $signed(req_tdata);
               state_in  = S_UPD;
            end
         end
         S_UPD: begin
            sum_in = sum_ff + SUM_W'(sample_ff) - SUM_W'(old_val);
            wp_in  = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
            if (startup_ff <= FILL_N) begin
               startup_in   = startup_ff + 1'b1;
               res_ready_in = 1'b0;
               state_in     = S_DONE;
            end else begin
               res_ready_in = 1'b1;
               mx_in        = 16'sh8000;
               mn_in        = 16'sh7fff;
               scan_in      = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            cmp_vld_in = 1'b1;
            scan_in    = scan_ff + 1'b1;
            if (scan_ff == LAST_ADDR) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            range_in      = diff[15:0];
            res_silent_in = cand;
            if (!silent_ff && cand) begin
               if (hold_ff < hold_count_ff) begin
                  hold_in       = hold_ff + 1'b1;
                  res_silent_in = 1'b0;
               end else begin
                  hold_in = '0;
               end
            end
            silent_in = res_silent_in;
            quo_in    = div_p[REC_K +: 16];
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (res_ready_ff) begin
                  rsp_data_in = {6'd0, range_ff, quo_ff ^ 16'h8000, res_silent_ff, 1'b1};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wp_ff         <= '0;
         startup_ff    <= '0;
         sum_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         hold_ff       <= '0;
         silent_ff     <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         threshold_ff  <= asg_pkg::THRESHOLD_RST;
         hold_count_ff <= asg_pkg::HOLD_RST;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         startup_ff   <= startup_in;
         sum_ff       <= sum_in;
         cmp_vld_ff   <= cmp_vld_in;
         hold_ff      <= hold_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               asg_pkg::CSR_THRESHOLD: threshold_ff  <= csr_data[asg_pkg::THRESH_W-1:0];
               asg_pkg::CSR_HOLD:      hold_count_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      scan_ff       <= scan_in;
      mx_ff         <= mx_in;
      mn_ff         <= mn_in;
      res_ready_ff  <= res_ready_in;
      res_silent_ff <= res_silent_in;
      range_ff      <= range_in;
      quo_ff        <= quo_in;
      rsp_data_ff   <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_startup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[0] |-> rsp_data_ff[33:1] == '0)
      else $error("start-up result carries non-zero fields");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is in work");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      startup_ff <= FILL_N + 1'b1)
      else $error("fill count ran past the window");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && !rsp_tready |=> state_ff == S_DONE)
      else $error("result dropped while output register full");
`endif

endmodule
